FILE: hw/rtl/ost_pkg.sv
// Package for the order slot table: sizes, command kinds and the beat that
// travels along the slot chain. No dependencies.
package ost_pkg;

  localparam int SLOTS    = 16;
  localparam int ID_WIDTH = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FIELD_W  = 16;
  localparam int KIND_W   = 2;
  localparam int CMP_W    = (ID_WIDTH > FIELD_W) ? ID_WIDTH : FIELD_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_INSERT   = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_FIND     = 2'd3
  } ost_kind_t;

  typedef struct packed {
    ost_kind_t            kind;
    logic [FIELD_W-1:0]   order_id;
    logic [FIELD_W-1:0]   client_id;
    logic [FIELD_W-1:0]   weight;
    logic [ID_WIDTH-1:0]  new_id;
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
  } ost_beat_t;

endpackage

FILE: hw/rtl/ost_cell.sv
// One slot of the order slot table: holds the record and acts on the command
// beat passing through, then hands the beat to the next slot. Uses ost_pkg.
module ost_cell
  import ost_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] idx,
  input  logic              in_valid,
  input  ost_beat_t         in_beat,
  output logic              out_valid,
  output ost_beat_t         out_beat
);

  logic                valid;
  logic [ID_WIDTH-1:0] slot_id;
  logic [FIELD_W-1:0]  slot_client;
  logic [FIELD_W-1:0]  slot_weight;
  logic                pending;

  logic      claim;
  logic      match;
  logic      take;
  ost_beat_t beat_next;

  always_comb begin
    match = valid && (CMP_W'(slot_id) == CMP_W'(in_beat.order_id));
    claim = 1'b0;
    take  = 1'b0;
    unique case (in_beat.kind)
      KIND_CLEAR:    take = 1'b0;
      KIND_INSERT:   take = !in_beat.hit && !valid;
      KIND_COMPLETE: take = !in_beat.hit && match;
      KIND_FIND:     take = !in_beat.hit && match;
      default:       take = 1'b0;
    endcase
    claim = in_valid && take;
    beat_next = in_beat;
    if (take) begin
      beat_next.hit  = 1'b1;
      beat_next.slot = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid && in_beat.kind == KIND_CLEAR) begin
        valid <= 1'b0;
      end else if (claim && in_beat.kind == KIND_INSERT) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= beat_next;
    if (claim && in_beat.kind == KIND_INSERT) begin
      slot_id     <= in_beat.new_id;
      slot_client <= in_beat.client_id;
      slot_weight <= in_beat.weight;
      pending     <= 1'b1;
    end else if (claim && in_beat.kind == KIND_COMPLETE) begin
      slot_client <= in_beat.client_id;
      slot_weight <= in_beat.weight;
      pending     <= 1'b0;
    end
  end

  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    claim && in_beat.kind == KIND_INSERT |=> valid && pending)
    else $error("insert did not fill slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_beat.kind == KIND_CLEAR |=> !valid)
    else $error("clear left slot valid");

  a_hit_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_beat.hit |=> out_valid && out_beat.hit && out_beat.slot == $past(in_beat.slot))
    else $error("earlier hit overwritten");

endmodule

FILE: hw/rtl/order_slot_table.sv
// Order slot table top level: input stage, chain of SLOTS slot cells, result
// hold and output register, id counter. Uses ost_pkg and ost_cell.
// A command passes the input register, the SLOTS slot cells, the result hold
// and the output register; no new command is taken until its result leaves the hold.
// A new command is taken while a finished result still waits at the output.
// Reset (rst, synchronous): all slots empty, id counter zero, no beat in flight.
module order_slot_table
  import ost_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // order_id, client_id, weight
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status, slot_index, assigned_id, zero pad
);

  logic                busy;
  logic                in_valid;
  ost_beat_t           in_beat;
  logic                hold_valid;
  ost_beat_t           hold_beat;
  logic [ID_WIDTH-1:0] id_counter;
  logic [23:0]         m_data;

  logic                accept;
  logic                move;
  logic [ID_WIDTH-1:0] id_next;
  logic                res_status;
  logic [3:0]          res_index;
  logic [FIELD_W-1:0]  res_id;

  logic      chain_valid [SLOTS+1];
  ost_beat_t chain_beat  [SLOTS+1];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign move          = hold_valid && (!m_axis_tvalid || m_axis_tready);
  assign id_next       = (id_counter == '1) ? ID_WIDTH'(1) : id_counter + ID_WIDTH'(1);
  assign m_axis_tdata  = m_data;

  assign chain_valid[0] = in_valid;
  assign chain_beat[0]  = in_beat;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ost_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (SLOT_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_beat   (chain_beat[i]),
      .out_valid (chain_valid[i+1]),
      .out_beat  (chain_beat[i+1])
    );
  end

  always_comb begin
    res_status = !hold_beat.hit;
    res_index  = hold_beat.hit ? 4'(hold_beat.slot) : 4'd0;
    res_id     = '0;
    if (hold_beat.kind == KIND_CLEAR) begin
      res_status = 1'b0;
      res_index  = 4'd0;
    end else if (hold_beat.kind == KIND_INSERT && hold_beat.hit) begin
      res_id = FIELD_W'(hold_beat.new_id);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      in_valid      <= 1'b0;
      hold_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      id_counter    <= '0;
    end else begin
      in_valid <= accept;
      if (accept) begin
        busy <= 1'b1;
      end
      if (chain_valid[SLOTS]) begin
        hold_valid <= 1'b1;
        if (chain_beat[SLOTS].kind == KIND_INSERT && chain_beat[SLOTS].hit) begin
          id_counter <= chain_beat[SLOTS].new_id;
        end
      end
      if (move) begin
        hold_valid    <= 1'b0;
        busy          <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_beat.kind      <= ost_kind_t'(s_axis_tuser);
      in_beat.order_id  <= s_axis_tdata[15:0];
      in_beat.client_id <= s_axis_tdata[31:16];
      in_beat.weight    <= s_axis_tdata[47:32];
      in_beat.new_id    <= id_next;
      in_beat.hit       <= 1'b0;
      in_beat.slot      <= '0;
    end
    if (chain_valid[SLOTS]) begin
      hold_beat <= chain_beat[SLOTS];
    end
    if (move) begin
      m_data <= {3'b000, res_id, res_index, res_status};
    end
  end

  logic [SLOTS:0] chain_valid_vec;
  always_comb begin
    for (int k = 0; k <= SLOTS; k++) begin
      chain_valid_vec[k] = chain_valid[k];
    end
  end

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    $onehot0({chain_valid_vec, hold_valid}))
    else $error("more than one command in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("ready while command in flight");

  a_chain_busy: assert property (@(posedge clk) disable iff (rst)
    (|chain_valid_vec) || hold_valid |-> busy)
    else $error("beat in chain while idle");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    move && hold_beat.kind == KIND_INSERT && hold_beat.hit |-> hold_beat.new_id != '0)
    else $error("zero id handed out");

endmodule

FILE: dv/tb_order_slot_table.sv
// Self-checking testbench for order_slot_table: directed command table, then
// random insert/complete/find/clear traffic checked by a behavioral slot table.
// Depends on ost_pkg and the order_slot_table RTL.
module tb_order_slot_table;
  import ost_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 400;
  localparam int CALM_CMDS   = 80;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LATENCY     = SLOTS + 3;

  typedef struct {
    logic        status;
    logic [3:0]  slot;
    logic [15:0] aid;
  } result_t;

  typedef struct {
    ost_kind_t   kind;
    logic [15:0] oid;
    logic [15:0] client;
    logic [15:0] wt;
    bit          typed;
    result_t     want;
  } cmd_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // order_id, client_id, weight
  logic [1:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // status, slot_index, assigned_id, zero pad

  // behavioral copy of the slot table
  logic                rec_valid   [SLOTS];
  logic [ID_WIDTH-1:0] rec_id      [SLOTS];
  logic [15:0]         rec_client  [SLOTS];
  logic [15:0]         rec_weight  [SLOTS];
  logic                rec_pending [SLOTS];
  logic [ID_WIDTH-1:0] id_cnt;

  result_t  awaited[$];
  cmd_row_t directed[$];
  int       errors;
  int       cycles;
  bit       calm;

  order_slot_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      rec_valid[i]   = 1'b0;
      rec_id[i]      = '0;
      rec_client[i]  = '0;
      rec_weight[i]  = '0;
      rec_pending[i] = 1'b0;
    end
  endfunction

  // apply one command to the slot table, return its result
  function automatic result_t apply_command(ost_kind_t k, logic [15:0] oid,
                                            logic [15:0] client, logic [15:0] wt);
    result_t r;
    int      hit;
    r   = '{status: 1'b1, slot: '0, aid: '0};
    hit = -1;
    case (k)
      KIND_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) rec_valid[i] = 1'b0;
        r.status = 1'b0;
      end
      KIND_INSERT: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!rec_valid[i]) hit = i;
        if (hit >= 0) begin
          id_cnt           = (id_cnt == '1) ? ID_WIDTH'(1) : id_cnt + 1'b1;
          rec_valid[hit]   = 1'b1;
          rec_id[hit]      = id_cnt;
          rec_client[hit]  = client;
          rec_weight[hit]  = wt;
          rec_pending[hit] = 1'b1;
          r.status         = 1'b0;
          r.slot           = 4'(hit);
          r.aid            = 16'(id_cnt);
        end
      end
      default: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (rec_valid[i] && 32'(rec_id[i]) == 32'(oid)) hit = i;
        if (hit >= 0) begin
          if (k == KIND_COMPLETE) begin
            rec_client[hit]  = client;
            rec_weight[hit]  = wt;
            rec_pending[hit] = 1'b0;
          end
          r.status = 1'b0;
          r.slot   = 4'(hit);
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(ost_kind_t k, int oid, int client, int wt, bit typed,
                                  bit st = 1'b0, int idx = 0, int aid = 0);
    cmd_row_t row;
    row.kind   = k;
    row.oid    = 16'(oid);
    row.client = 16'(client);
    row.wt     = 16'(wt);
    row.typed  = typed;
    row.want   = '{status: st, slot: 4'(idx), aid: 16'(aid)};
    directed.push_back(row);
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s at cycle %0d: expected %0h, got %0h", what, cycles, want, got);
  endtask

  // drive one command beat and log its expected result on acceptance
  task automatic send_cmd(cmd_row_t row);
    result_t r;
    s_axis_tdata  = {row.wt, row.client, row.oid};
    s_axis_tuser  = row.kind;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    r = apply_command(row.kind, row.oid, row.client, row.wt);
    awaited.push_back(row.typed ? row.want : r);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin : mon
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited.size() == 0) begin
        note_mismatch("unexpected beat", 0, int'(m_axis_tdata));
      end else begin
        want = awaited.pop_front();
        if (m_axis_tdata[0] !== want.status)
          note_mismatch("status", want.status, m_axis_tdata[0]);
        if (m_axis_tdata[4:1] !== want.slot)
          note_mismatch("slot_index", want.slot, m_axis_tdata[4:1]);
        if (m_axis_tdata[20:5] !== want.aid)
          note_mismatch("assigned_id", want.aid, m_axis_tdata[20:5]);
      end
    end
  end

  // sink backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        m_axis_tready = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  initial begin
    cmd_row_t row;
    int       r;
    int       n_live;
    int       pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_CLEAR;
    errors        = 0;
    cycles        = 0;
    calm          = 1'b0;
    id_cnt        = '0;
    clear_table();

    add_row(KIND_FIND,     16'h0000, 16'h0000, 16'h0000, 1, 1'b1, 0, 0);
    add_row(KIND_COMPLETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b1, 0, 0);
    add_row(KIND_CLEAR,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b0, 0, 0);
    add_row(KIND_INSERT,   16'hFFFF, 16'h0000, 16'h0000, 1, 1'b0, 0, 1);
    add_row(KIND_INSERT,   16'h0000, 16'hFFFF, 16'hFFFF, 1, 1'b0, 1, 2);
    add_row(KIND_FIND,     16'h0001, 16'h0000, 16'h0000, 1, 1'b0, 0, 0);
    add_row(KIND_COMPLETE, 16'h0002, 16'h1234, 16'h5678, 1, 1'b0, 1, 0);
    add_row(KIND_FIND,     16'h0000, 16'hAAAA, 16'h5555, 1, 1'b1, 0, 0);
    for (int i = 2; i < SLOTS; i++)
      add_row(KIND_INSERT, 16'h5555 ^ i, 16'hA000 + i, 16'h0F00 + i, 0);
    add_row(KIND_INSERT,   16'hAAAA, 16'h5555, 16'hAAAA, 1, 1'b1, 0, 0);
    add_row(KIND_CLEAR,    16'h0000, 16'h0000, 16'h0000, 1, 1'b0, 0, 0);
    add_row(KIND_INSERT,   16'h0000, 16'h8001, 16'h7FFE, 1, 1'b0, 0, SLOTS + 1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_cmd(directed[i]);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS / 3) begin
        s_axis_tvalid = 1'b0;
        while (awaited.size() != 0) @(negedge clk);
      end
      calm       = (n >= RANDOM_CMDS - CALM_CMDS);
      r          = $urandom_range(0, 99);
      row.typed  = 0;
      row.want   = '{status: 1'b0, slot: '0, aid: '0};
      row.oid    = 16'($urandom_range(0, 65535));
      row.client = 16'($urandom_range(0, 65535));
      row.wt     = 16'($urandom_range(0, 65535));
      if (r < 4) row.kind = KIND_CLEAR;
      else if (r < 46) row.kind = KIND_INSERT;
      else if (r < 74) row.kind = KIND_COMPLETE;
      else row.kind = KIND_FIND;
      if (row.kind == KIND_COMPLETE || row.kind == KIND_FIND) begin
        n_live = 0;
        for (int i = 0; i < SLOTS; i++) if (rec_valid[i]) n_live++;
        r = $urandom_range(0, 99);
        if (n_live > 0 && r < 75) begin
          pick = $urandom_range(0, n_live - 1);
          for (int i = 0; i < SLOTS; i++) begin
            if (rec_valid[i]) begin
              if (pick == 0) row.oid = 16'(rec_id[i]);
              pick--;
            end
          end
        end else if (r < 85) begin
          // stale id of a slot that may have been cleared
          row.oid = 16'(rec_id[$urandom_range(0, SLOTS - 1)]);
        end else if (r < 90) begin
          row.oid = 16'(id_cnt + 1'b1);
        end
      end
      send_cmd(row);
    end

    s_axis_tvalid = 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
